// ----- rtl/core/lcgx_pkg.sv -----
// Shared constants, types and generator functions for the LCG keystream descrambler.
`timescale 1ns / 1ps
`default_nettype none
package lcgx_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned GEN_W  = 32;
	localparam int unsigned POS_W  = 4;
	localparam int unsigned KEY_W  = 3;
	localparam int unsigned PH5_W  = 3;

	localparam logic [GEN_W-1:0] LCG_MUL = 32'h0003_43FD;
	localparam logic [GEN_W-1:0] LCG_INC = 32'h0026_9EC3;

	// Byte offsets inside a buffer.
	localparam logic [POS_W-1:0] SEED_EVERY_POS  = 4'd0;
	localparam logic [POS_W-1:0] SEED_FIFTH_POS  = 4'd6;
	localparam logic [POS_W-1:0] SEED_SECOND_POS = 4'd8;
	localparam logic [POS_W-1:0] START_OFF       = 4'd10;

	localparam logic [PH5_W-1:0] FIFTH_LAST = 3'd4;

	// Key bits taken from each generator value.
	localparam int unsigned KEY_LSB = 28;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} lcgx_beat_t;

	function automatic logic [GEN_W-1:0] lcg_next(input logic [GEN_W-1:0] g);
		lcg_next = GEN_W'(g * LCG_MUL + LCG_INC);
	endfunction

	function automatic logic [KEY_W-1:0] lcg_key(input logic [GEN_W-1:0] g);
		lcg_key = g[KEY_LSB +: KEY_W];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/lcgx_if.sv -----
// Valid/ready stream interfaces for the scrambled and descrambled byte channels.
`timescale 1ns / 1ps
`default_nettype none
interface lcgx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_in_buffer;

	modport source (output valid, output data_byte, output last_in_buffer, input ready);
	modport sink   (input valid, input data_byte, input last_in_buffer, output ready);
endinterface

interface lcgx_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/lcg_keystream_xor_descrambler.sv -----
// Top level of the LCG keystream XOR descrambler: input register, key merge, result register.
//
// Usage:
//  - scrambled (sink): one beat per buffer byte, data_byte plus last_in_buffer,
//    which marks the final byte; the following beat opens a new buffer.
//  - descrambled (source): one beat per input beat, in order, out_byte is the
//    descrambled byte and out_last copies the marker.
//  - Bytes 0, 6 and 8 of a buffer seed three 32-bit generators; bytes 0..9 pass
//    through unchanged, from byte 10 on each byte is XORed with the merged keys.
//  - Path: the input beat passes the input register, then the result register, to
//    the output beat. Throughput: one byte per cycle while descrambled is ready;
//    the generator update is one 32x18 constant multiply-add per generator, fed back as it steps.
//  - Stall: while descrambled is held off, the result register keeps its beat and
//    the input register takes one more; ready drops only when both are full.
//  - Reset (arst_n low): drop both registers, clear the generators and phases;
//    the first beat after reset is byte 0 of a buffer.
`timescale 1ns / 1ps
`default_nettype none
module lcg_keystream_xor_descrambler
	import lcgx_pkg::*;
(
	input wire logic   clk,
	input wire logic   arst_n,
	lcgx_in_if.sink    scrambled,
	lcgx_out_if.source descrambled
);

	// Stage 1: input register
	logic        valid_s1;
	lcgx_beat_t  beat_s1;
	// Stage 2: result register
	logic              valid_s2;
	logic [BYTE_W-1:0] byte_s2;
	logic              last_s2;

	logic              advance;
	logic              take;
	logic [BYTE_W-1:0] res;

	// Move stage 1 forward when the result register is empty or being drained.
	assign advance = valid_s1 && (!valid_s2 || descrambled.ready);
	assign scrambled.ready = !valid_s1 || advance;
	assign take = scrambled.valid && scrambled.ready;

	lcgx_keystream u_keystream (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.beat   (beat_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (descrambled.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers: load only on a beat, hold otherwise.
	always_ff @(posedge clk) begin
		if (take) begin
			beat_s1.data <= scrambled.data_byte;
			beat_s1.last <= scrambled.last_in_buffer;
		end
		if (advance) begin
			byte_s2 <= res;
			last_s2 <= beat_s1.last;
		end
	end

	assign descrambled.valid    = valid_s2;
	assign descrambled.out_byte = byte_s2;
	assign descrambled.out_last = last_s2;

endmodule
`default_nettype wire

// ----- rtl/core/lcgx_keystream.sv -----
// Generator state, seeding and per-byte key merge of the descrambler.
`timescale 1ns / 1ps
`default_nettype none
module lcgx_keystream
	import lcgx_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire lcgx_beat_t        beat,
	output logic      [BYTE_W-1:0] res
);

	logic [POS_W-1:0] pos_q;
	logic [GEN_W-1:0] gen_every_q;
	logic [GEN_W-1:0] gen_second_q;
	logic [GEN_W-1:0] gen_fifth_q;
	logic             even_q;
	logic [PH5_W-1:0] fifth_q;

	logic [GEN_W-1:0] every_nx;
	logic [GEN_W-1:0] second_nx;
	logic [GEN_W-1:0] fifth_nx;
	logic             scramble;
	logic [KEY_W-1:0] key;

	assign scramble  = (pos_q >= START_OFF);
	assign every_nx  = lcg_next(gen_every_q);
	assign second_nx = lcg_next(gen_second_q);
	assign fifth_nx  = lcg_next(gen_fifth_q);

	always_comb begin
		key = lcg_key(every_nx);
		if (!even_q) begin
			key = key ^ lcg_key(second_nx);
		end
		if (fifth_q == '0) begin
			key = key ^ lcg_key(fifth_nx);
		end
		res = scramble ? (beat.data ^ {{(BYTE_W-KEY_W){1'b0}}, key}) : beat.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			gen_every_q  <= '0;
			gen_second_q <= '0;
			gen_fifth_q  <= '0;
			even_q       <= 1'b0;
			fifth_q      <= '0;
		end else if (step) begin
			if (beat.last) begin
				// end of buffer: start the next one from scratch
				pos_q        <= '0;
				gen_every_q  <= '0;
				gen_second_q <= '0;
				gen_fifth_q  <= '0;
				even_q       <= 1'b0;
				fifth_q      <= '0;
			end else if (!scramble) begin
				unique case (pos_q)
					SEED_EVERY_POS:  gen_every_q  <= {{(GEN_W-BYTE_W){1'b0}}, beat.data};
					SEED_FIFTH_POS:  gen_fifth_q  <= {{(GEN_W-BYTE_W){1'b0}}, beat.data};
					SEED_SECOND_POS: gen_second_q <= {{(GEN_W-BYTE_W){1'b0}}, beat.data};
					default: ;
				endcase
				pos_q <= pos_q + POS_W'(1);
			end else begin
				gen_every_q <= every_nx;
				if (!even_q) begin
					gen_second_q <= second_nx;
				end
				even_q <= ~even_q;
				if (fifth_q == '0) begin
					gen_fifth_q <= fifth_nx;
				end
				fifth_q <= (fifth_q >= FIFTH_LAST) ? '0 : fifth_q + PH5_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/lcgx_checker.sv -----
// Port-level checks of the descrambler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lcgx_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       out_last
);

	logic       in_beat;
	logic       out_beat;
	logic [1:0] held_q;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// Beats taken in but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else begin
			held_q <= held_q + 2'(in_beat) - 2'(out_beat);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("stalled output beat changed");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused with empty output");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && !out_valid |=> ##1 out_valid)
		else $error("output beat late");

	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		held_q != 2'd3)
		else $error("more than two beats in flight");

endmodule

bind lcg_keystream_xor_descrambler lcgx_checker u_lcgx_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (scrambled.valid),
	.in_ready  (scrambled.ready),
	.out_valid (descrambled.valid),
	.out_ready (descrambled.ready),
	.out_byte  (descrambled.out_byte),
	.out_last  (descrambled.out_last)
);
`default_nettype wire

// ----- tb/lcgx_tb_pkg.sv -----
// Scoreboard for the descrambler: models the three generators and holds the expected bytes.
`timescale 1ns / 1ps
package lcgx_tb_pkg;
	import lcgx_pkg::*;

	localparam int unsigned REPORT_LIMIT = 10;

	class descramble_scoreboard;
		logic [POS_W-1:0] offset;
		logic [GEN_W-1:0] gen_every;
		logic [GEN_W-1:0] gen_second;
		logic [GEN_W-1:0] gen_fifth;
		logic             even_phase;
		logic [PH5_W-1:0] fifth_phase;
		lcgx_beat_t       plain_q[$];
		int unsigned      mismatches;

		function new();
			mismatches = 0;
			restart_buffer();
		endfunction

		function void restart_buffer();
			offset      = '0;
			gen_every   = '0;
			gen_second  = '0;
			gen_fifth   = '0;
			even_phase  = 1'b0;
			fifth_phase = '0;
		endfunction

		// Advance one generator and return its key bits.
		function logic [KEY_W-1:0] advance(inout logic [GEN_W-1:0] g);
			g = g * LCG_MUL + LCG_INC;
			return g[KEY_LSB +: KEY_W];
		endfunction

		function int unsigned pending();
			return plain_q.size();
		endfunction

		function void note_scrambled(input logic [BYTE_W-1:0] d, input logic l);
			lcgx_beat_t plain;
			plain.data = d;
			plain.last = l;
			if (offset < START_OFF) begin
				// Bytes before the start offset pass through unchanged; seed bytes load a generator.
				if (offset == SEED_EVERY_POS)
					gen_every = GEN_W'(d);
				else if (offset == SEED_FIFTH_POS)
					gen_fifth = GEN_W'(d);
				else if (offset == SEED_SECOND_POS)
					gen_second = GEN_W'(d);
				offset = offset + 1'b1;
			end else begin
				plain.data = plain.data ^ BYTE_W'(advance(gen_every));
				if (!even_phase)
					plain.data = plain.data ^ BYTE_W'(advance(gen_second));
				even_phase = ~even_phase;
				if (fifth_phase == '0)
					plain.data = plain.data ^ BYTE_W'(advance(gen_fifth));
				fifth_phase = (fifth_phase >= FIFTH_LAST) ? '0 : fifth_phase + 1'b1;
			end
			plain_q.push_back(plain);
			if (l)
				restart_buffer();
		endfunction

		function void complain(input string what);
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("mismatch: %s", what);
		endfunction

		function void check_descrambled(input logic [BYTE_W-1:0] d, input logic l);
			lcgx_beat_t plain;
			if (plain_q.size() == 0) begin
				complain($sformatf("unexpected beat out_byte=%02h out_last=%0b", d, l));
				return;
			end
			plain = plain_q.pop_front();
			if (d !== plain.data)
				complain($sformatf("out_byte expected %02h actual %02h", plain.data, d));
			if (l !== plain.last)
				complain($sformatf("out_last expected %0b actual %0b", plain.last, l));
		endfunction
	endclass
endpackage

// ----- tb/tb_top.sv -----
// Top of the descrambler testbench: clock, reset, beat driver, result checker and run control.
`timescale 1ns / 1ps
module tb_top;
	import lcgx_pkg::*;
	import lcgx_tb_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 400_000;
	localparam int unsigned TOTAL_BEATS  = 1025;
	localparam int unsigned IDLE_PERCENT = 28;
	localparam int unsigned CALM_FIRST   = 300;
	localparam int unsigned CALM_LAST    = 450;
	localparam int unsigned PAUSE_AT     = 600;
	localparam int unsigned TAIL_CYCLES  = 8;

	typedef enum int unsigned {
		FILL_RANDOM,
		FILL_ONES,
		FILL_ZEROS,
		FILL_ALTERNATE
	} fill_t;

	logic clk = 1'b0;
	logic arst_n;
	logic calm;
	int unsigned beats_sent;
	descramble_scoreboard sb;

	lcgx_in_if  scrambled_bus ();
	lcgx_out_if descrambled_bus ();

	lcg_keystream_xor_descrambler i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.scrambled   (scrambled_bus),
		.descrambled (descrambled_bus)
	);

	// 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Offer one scrambled beat and hold it until the block takes it.
	// Random idle cycles go in front of the beat unless the calm stretch is on.
	task automatic send_beat(input logic [BYTE_W-1:0] d, input logic l);
		calm <= (beats_sent >= CALM_FIRST) && (beats_sent < CALM_LAST);
		while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
			scrambled_bus.valid <= 1'b0;
			@(posedge clk);
		end
		scrambled_bus.valid          <= 1'b1;
		scrambled_bus.data_byte      <= d;
		scrambled_bus.last_in_buffer <= l;
		// Ready is read before this edge's updates land, so it is the value
		// the block saw at the edge.
		do
			@(posedge clk);
		while (!scrambled_bus.ready);
		sb.note_scrambled(d, l);
		beats_sent++;
	endtask

	// Stream one whole buffer; the marker goes on its final byte.
	task automatic send_buffer(input int unsigned len, input fill_t fill);
		logic [BYTE_W-1:0] d;
		for (int unsigned i = 0; i < len; i++) begin
			case (fill)
				FILL_ONES:      d = '1;
				FILL_ZEROS:     d = '0;
				FILL_ALTERNATE: d = i[0] ? 8'h00 : 8'hFF;
				default:        d = BYTE_W'($urandom_range(255));
			endcase
			send_beat(d, i == len - 1);
		end
	endtask

	// Drop valid and hold off until every descrambled beat is back.
	task automatic drain_results();
		scrambled_bus.valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	// Check each accepted result beat, then pick ready for the next edge.
	always @(posedge clk) begin
		if (descrambled_bus.valid && descrambled_bus.ready)
			sb.check_descrambled(descrambled_bus.out_byte, descrambled_bus.out_last);
		descrambled_bus.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
	end

	initial begin
		int unsigned pick;
		int unsigned len;
		logic        paused;
		sb     = new();
		arst_n = 1'b0;
		calm   = 1'b0;
		paused = 1'b0;
		beats_sent = 0;
		scrambled_bus.valid          = 1'b0;
		scrambled_bus.data_byte      = '0;
		scrambled_bus.last_in_buffer = 1'b0;
		descrambled_bus.ready        = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Single-byte buffer, a short buffer that ends before the keystream
		// starts, and one that crosses into it with extreme byte values.
		send_buffer(1, FILL_ONES);
		send_buffer(9, FILL_ZEROS);
		send_buffer(15, FILL_ALTERNATE);
		drain_results();

		// Mostly buffers long enough to reach the keystream, some short ones
		// and a few long ones to cycle both phases many times.
		while (beats_sent < TOTAL_BEATS) begin
			pick = $urandom_range(99);
			if (pick < 15)
				len = $urandom_range(10, 1);
			else if (pick < 92)
				len = $urandom_range(40, 11);
			else
				len = $urandom_range(150, 60);
			send_buffer(len, FILL_RANDOM);
			if (!paused && beats_sent >= PAUSE_AT) begin
				drain_results();
				paused = 1'b1;
			end
		end

		scrambled_bus.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog: end a hung run.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
